// ===== sv/sliding_window_event_limiter_top_macros.svh =====
// Assertion helpers for the event limiter.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef SLIDING_WINDOW_EVENT_LIMITER_TOP_MACROS_SVH
`define SLIDING_WINDOW_EVENT_LIMITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/swel_pkg.sv =====
`timescale 1ns / 1ps

package swel_pkg;

  localparam int CNT_W     = 24;
  localparam int TIME_W    = 48;
  localparam int SPAN_W    = 16;
  localparam int MAXC_W    = 24;
  localparam int DIV_W     = 26;  // holds any span in microseconds
  localparam int QUO_W     = 17;  // holds any quotient the block needs
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int US_PER_MS = 1000;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command codes.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes (word address).
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_BUCKET = 2'd1;
  localparam logic [1:0] REG_MAXC   = 2'd2;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic             full_res;
    logic [CNT_W-1:0] event_total;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/swel_ram.sv =====
`timescale 1ns / 1ps

module swel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/swel_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first. Alongside the
// quotient it keeps the quotient modulo a small modulus, one compare and
// subtract per bit.
module swel_div import swel_pkg::*; #(
  parameter int MW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_req_t      req,
  input  logic [MW-1:0] modulus,
  output div_rsp_t      rsp,
  output logic [MW-1:0] qmod
);

  localparam int SH_W  = DIV_W + QUO_W - 1;
  localparam int CNT_W_L = $clog2(QUO_W);

  logic               run_r;
  logic               done_r;
  logic [CNT_W_L-1:0] cnt_r;
  logic [DIV_W-1:0]   rem_r;
  logic [SH_W-1:0]    dsh_r;
  logic [QUO_W-1:0]   quo_r;
  logic [MW-1:0]      qmod_r;

  logic               ge;
  logic [MW:0]        qm_ext;
  logic [MW-1:0]      qmod_nxt;

  always_comb begin
    ge       = SH_W'(rem_r) >= dsh_r;
    qm_ext   = {qmod_r, ge};
    qmod_nxt = (qm_ext >= (MW+1)'(modulus)) ? MW'(qm_ext - (MW+1)'(modulus))
                                           : MW'(qm_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W_L'(QUO_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      dsh_r  <= SH_W'(req.den) << (QUO_W - 1);
      quo_r  <= '0;
      qmod_r <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[DIV_W-1:0];
      end
      dsh_r  <= dsh_r >> 1;
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      qmod_r <= qmod_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;
  assign qmod     = qmod_r;

endmodule

// ===== sv/sliding_window_event_limiter_top.sv =====
// Steps from acceptance to the result: with limiting disabled, or for a query that clears the
// ring, the result follows the window check. Otherwise the divider runs unless the ring clears,
// each passed bucket (at most the ring size) is read out, and a check then updates its count.
// Throughput: busy drops with the result strobe, so the next transaction may follow at once.
// A write to window_ms or bucket_ms holds busy while the ring size is divided.
// Synchronous active-low reset clears all counts at once through per-bucket valid bits.
`timescale 1ns / 1ps
`include "sliding_window_event_limiter_top_macros.svh"

module sliding_window_event_limiter_top import swel_pkg::*; #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  // Result channel.
  output logic               out_valid,
  output out_item_t          out_item,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // AW indexes the bucket store; NBW holds a ring size up to MAX_BUCKETS.
  localparam int AW  = $clog2(MAX_BUCKETS);
  localparam int NBW = $clog2(MAX_BUCKETS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NBDIV = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_ADV   = 7'b0010000,
    S_CNTRD = 7'b0100000,
    S_CNTWR = 7'b1000000
  } state_t;

  // Configuration registers and values derived from them.
  logic [SPAN_W-1:0]      window_r;
  logic [SPAN_W-1:0]      bucket_r;
  logic [MAXC_W-1:0]      max_count_r;
  logic [DIV_W-1:0]       win_us_r;
  logic [DIV_W-1:0]       bkt_us_r;
  logic [NBW-1:0]         nb_r;
  logic                   nb_pend_r;

  // Control and window state.
  state_t                 state_r, state_nxt;
  logic                   cmd_r;
  logic [TIME_W-1:0]      now_r;
  logic [TIME_W-1:0]      ref_r;
  logic [CNT_W-1:0]       wtot_r, wtot_nxt;
  logic [AW-1:0]          cur_r;
  logic [MAX_BUCKETS-1:0] valid_r;
  logic [NBW-1:0]         adv_left_r;
  logic [AW-1:0]          adv_pos_r;
  logic                   rd_pend_r;
  logic [AW-1:0]          rd_addr_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // Datapath signals.
  logic                   cfg_wr;
  logic                   span_wr;
  logic                   enabled;
  logic                   accept;
  logic [TIME_W:0]        diff;
  logic                   clear_hit;
  logic [AW-1:0]          pos_inc;
  logic [CNT_W-1:0]       cnt_eff;
  logic                   emit;
  logic                   full_nxt;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic                   ram_we;
  logic [CNT_W-1:0]       ram_wdata;
  logic [CNT_W-1:0]       ram_rdata;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [NBW-1:0]         div_qmod;
  logic [NBW-1:0]         adv_k;
  logic [NBW:0]           cur_sum;
  logic [AW-1:0]          cur_new;
  logic [NBW-1:0]         nb_new;

  // All bucket counts sit in one single-port-write, single-port-read memory.
  // An entry whose valid bit is clear reads as zero, so a clear of the whole
  // ring is a reset of the valid vector.
  swel_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BUCKETS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The shared divider computes the ring size after a span write and the
  // number of elapsed buckets for each enabled transaction that does not clear the ring.
  swel_div #(
    .MW (NBW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .modulus (nb_r),
    .rsp     (div_rsp),
    .qmod    (div_qmod)
  );

  assign cfg_wr  = psel && penable && pwrite;
  assign span_wr = cfg_wr && (paddr[3:2] inside {REG_WINDOW, REG_BUCKET});
  assign enabled = (window_r != '0) && (bucket_r != '0);
  assign busy    = (state_r != S_IDLE) || nb_pend_r;
  assign accept  = start && !busy;

  always_comb begin
    // Elapsed time since the reference, with the borrow kept in the top bit.
    diff      = {1'b0, now_r} - {1'b0, ref_r};
    clear_hit = diff[TIME_W] || (diff[TIME_W-1:0] > TIME_W'(win_us_r));

    pos_inc = ((NBW'(adv_pos_r) + NBW'(1)) == nb_r) ? '0 : adv_pos_r + 1'b1;
    cnt_eff = valid_r[rd_addr_r] ? ram_rdata : '0;

    // The ring moves on by at most one full turn; the final position moves
    // by the elapsed bucket count modulo the ring size.
    adv_k   = (div_rsp.quo >= QUO_W'(nb_r)) ? nb_r : NBW'(div_rsp.quo);
    cur_sum = (NBW+1)'(cur_r) + (NBW+1)'(div_qmod);
    cur_new = (cur_sum >= (NBW+1)'(nb_r)) ? AW'(cur_sum - (NBW+1)'(nb_r))
                                          : AW'(cur_sum);

    if (div_rsp.quo > QUO_W'(MAX_BUCKETS)) begin
      nb_new = NBW'(MAX_BUCKETS);
    end else if (div_rsp.quo == '0) begin
      nb_new = NBW'(1);
    end else begin
      nb_new = NBW'(div_rsp.quo);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wtot_nxt    = wtot_r;
    emit        = 1'b0;
    full_nxt    = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cur_r;
    ram_we      = 1'b0;
    ram_wdata   = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
    div_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (nb_pend_r) begin
          // Ring size is ceil(window / bucket).
          if (bucket_r != '0) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(window_r) + DIV_W'(bucket_r) - DIV_W'(1);
            div_req.den   = DIV_W'(bucket_r);
            state_nxt     = S_NBDIV;
          end
        end else if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_NBDIV: begin
        if (div_rsp.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!enabled) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (clear_hit) begin
          wtot_nxt = '0;
          if (cmd_r == CMD_CHECK) begin
            state_nxt = S_CNTRD;
          end else begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = diff[DIV_W-1:0];
          div_req.den   = bkt_us_r;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quo != '0) begin
            state_nxt = S_ADV;
          end else if (cmd_r == CMD_CHECK) begin
            state_nxt = S_CNTRD;
          end else begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADV: begin
        // One bucket read per cycle; its count leaves the total in the next cycle.
        if (rd_pend_r) begin
          wtot_nxt = (wtot_r >= cnt_eff) ? wtot_r - cnt_eff : '0;
        end
        if (adv_left_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = pos_inc;
        end else if (!rd_pend_r) begin
          if (cmd_r == CMD_CHECK) begin
            state_nxt = S_CNTRD;
          end else begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_CNTRD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
        state_nxt = S_CNTWR;
      end
      S_CNTWR: begin
        ram_we    = 1'b1;
        wtot_nxt  = (wtot_r == CNT_MAX) ? wtot_r : wtot_r + 1'b1;
        full_nxt  = (max_count_r != '0) && (wtot_nxt >= max_count_r);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A span write empties the total and leaves the sequencer idle.
    if (span_wr) begin
      wtot_nxt  = '0;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= '0;
      bucket_r    <= '0;
      max_count_r <= '0;
      nb_r        <= NBW'(1);
      nb_pend_r   <= 1'b0;
      ref_r       <= '0;
      wtot_r      <= '0;
      cur_r       <= '0;
      valid_r     <= '0;
      adv_left_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wtot_r      <= wtot_nxt;
      out_valid_r <= emit;
      rd_pend_r   <= (state_r == S_ADV) && ram_re;

      if ((state_r == S_IDLE) && nb_pend_r && (bucket_r == '0)) begin
        nb_r      <= NBW'(1);
        nb_pend_r <= 1'b0;
      end
      if ((state_r == S_NBDIV) && div_rsp.done) begin
        nb_r      <= nb_new;
        nb_pend_r <= 1'b0;
      end

      if ((state_r == S_CHECK) && enabled && clear_hit) begin
        valid_r <= '0;
        cur_r   <= '0;
        ref_r   <= now_r;
      end

      if ((state_r == S_DIV) && div_rsp.done && (div_rsp.quo != '0)) begin
        // Advancing by whole buckets leaves the remainder past the reference.
        adv_left_r <= adv_k;
        adv_pos_r  <= cur_r;
        cur_r      <= cur_new;
        ref_r      <= now_r - TIME_W'(div_rsp.rem);
      end

      if (state_r == S_ADV) begin
        if (rd_pend_r) begin
          valid_r[rd_addr_r] <= 1'b0;
        end
        if (adv_left_r != '0) begin
          adv_left_r <= adv_left_r - 1'b1;
          adv_pos_r  <= pos_inc;
        end
      end

      if (state_r == S_CNTWR) begin
        valid_r[cur_r] <= 1'b1;
      end

      // A span write empties the ring and schedules a new ring size.
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_WINDOW: begin
            window_r  <= pwdata[SPAN_W-1:0];
            valid_r   <= '0;
            cur_r     <= '0;
            nb_pend_r <= 1'b1;
          end
          REG_BUCKET: begin
            bucket_r  <= pwdata[SPAN_W-1:0];
            valid_r   <= '0;
            cur_r     <= '0;
            nb_pend_r <= 1'b1;
          end
          REG_MAXC: begin
            max_count_r <= pwdata[MAXC_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    win_us_r <= DIV_W'(window_r * US_PER_MS);
    bkt_us_r <= DIV_W'(bucket_r * US_PER_MS);
    if (accept) begin
      cmd_r <= in_item.command;
      now_r <= in_item.now_us;
    end
    if (ram_re) begin
      rd_addr_r <= ram_raddr;
    end
    if (emit) begin
      out_item_r.full_res    <= full_nxt;
      out_item_r.event_total <= wtot_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = PDATA_W'(window_r);
      REG_BUCKET: prdata = PDATA_W'(bucket_r);
      REG_MAXC:   prdata = PDATA_W'(max_count_r);
      default:    prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SWEL_ASSERT_NEXT(a_no_result_after_accept, accept, !out_valid,
                    "result strobe in the cycle right after a transaction was accepted")
  `SWEL_ASSERT_NOW(a_result_when_idle, out_valid, state_r == S_IDLE,
                   "result strobe while the sequencer is still working")
  `SWEL_ASSERT_NOW(a_full_needs_limit, out_valid && out_item.full_res, max_count_r != '0,
                   "full reported with no limit set")
  `SWEL_ASSERT_NOW(a_cur_in_ring, 1'b1, NBW'(cur_r) < nb_r,
                   "current bucket outside the ring")
  `SWEL_ASSERT_NOW(a_adv_bounded, state_r == S_ADV, adv_left_r <= nb_r,
                   "ring advance longer than one full turn")

endmodule

// ===== sim/swel_checker.sv =====
`timescale 1ns / 1ps

module swel_checker import swel_pkg::*; #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending_count
);

  // Shadow copy of the limiter state and its registers.
  logic [CNT_W-1:0]  bkt_cnt [MAX_BUCKETS];
  logic [CNT_W-1:0]  win_total;
  int unsigned       cur_pos;
  logic [TIME_W-1:0] ref_time;
  logic [SPAN_W-1:0] win_ms;
  logic [SPAN_W-1:0] bkt_ms;
  logic [MAXC_W-1:0] limit_cnt;

  out_item_t expected_results [$];

  function automatic void clear_counts();
    for (int i = 0; i < MAX_BUCKETS; i++) bkt_cnt[i] = '0;
    win_total = '0;
    cur_pos   = 0;
  endfunction

  function automatic int unsigned ring_len();
    int unsigned n;
    n = (32'(win_ms) + 32'(bkt_ms) - 1) / 32'(bkt_ms);
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    if (n < 1) n = 1;
    return n;
  endfunction

  // Moves the ring on to the stamp, or clears it when the stamp is out of the window.
  function automatic void roll_window(logic [TIME_W-1:0] now);
    longint unsigned win_us;
    longint unsigned bkt_us;
    longint unsigned elapsed;
    longint unsigned steps;
    longint unsigned k;
    int unsigned     nb;
    int unsigned     pos;
    nb = ring_len();
    if (cur_pos >= nb) cur_pos = 0;
    win_us = 64'(win_ms) * 64'(US_PER_MS);
    bkt_us = 64'(bkt_ms) * 64'(US_PER_MS);
    if (now < ref_time) begin
      clear_counts();
      ref_time = now;
      return;
    end
    elapsed = 64'(now - ref_time);
    if (elapsed > win_us) begin
      clear_counts();
      ref_time = now;
      return;
    end
    steps = elapsed / bkt_us;
    if (steps == 0) return;
    pos = cur_pos;
    k   = (steps < nb) ? steps : 64'(nb);
    while (k > 0) begin
      pos = (pos + 1) % nb;
      if (win_total >= bkt_cnt[pos]) win_total = win_total - bkt_cnt[pos];
      else win_total = '0;
      bkt_cnt[pos] = '0;
      k--;
    end
    cur_pos  = (cur_pos + 32'(steps % nb)) % nb;
    ref_time = TIME_W'(64'(ref_time) + steps * bkt_us);
  endfunction

  function automatic out_item_t limiter_result(in_item_t it);
    out_item_t r;
    r.full_res = 1'b0;
    if (win_ms != '0 && bkt_ms != '0) begin
      roll_window(it.now_us);
      if (it.command == CMD_CHECK) begin
        if (win_total != CNT_MAX) win_total++;
        if (bkt_cnt[cur_pos] != CNT_MAX) bkt_cnt[cur_pos]++;
        if (limit_cnt != '0 && win_total >= limit_cnt) r.full_res = 1'b1;
      end
    end
    r.event_total = win_total;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      win_ms     = '0;
      bkt_ms     = '0;
      limit_cnt  = '0;
      ref_time   = '0;
      fail_count = 0;
      clear_counts();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing expected: full_res=%0d event_total=%0d",
                     $realtime, out_item.full_res, out_item.event_total);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.full_res !== want.full_res ||
              out_item.event_total !== want.event_total) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected full_res=%0d event_total=%0d, got %0d %0d",
                       $realtime, want.full_res, want.event_total,
                       out_item.full_res, out_item.event_total);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_WINDOW: begin
            win_ms = pwdata[SPAN_W-1:0];
            clear_counts();
          end
          REG_BUCKET: begin
            bkt_ms = pwdata[SPAN_W-1:0];
            clear_counts();
          end
          REG_MAXC: limit_cnt = pwdata[MAXC_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_results.push_back(limiter_result(in_item));
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== sim/tb_sliding_window_event_limiter_top.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_event_limiter_top;
  import swel_pkg::*;

  localparam int NUM_BUCKETS = 64;
  // Index past the three registers; a write there must leave the block untouched.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 10;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  in_item_t           in_item = '0;
  logic               busy;
  logic               out_valid;
  out_item_t          out_item;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending_count;

  // Sender gaps are switched off for one whole phase to get back-to-back traffic.
  bit gaps_on = 1'b1;

  // Running time stamp of the stimulus and the current spans in microseconds.
  logic [TIME_W-1:0] t_now  = '0;
  longint unsigned   win_us = 0;
  longint unsigned   bkt_us = 0;

  always #10 clk = ~clk;

  sliding_window_event_limiter_top #(
    .MAX_BUCKETS(NUM_BUCKETS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // The checker watches both channels and the register port, predicts every
  // result and counts mismatches; this module only makes stimulus.
  swel_checker #(
    .MAX_BUCKETS(NUM_BUCKETS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // One register write: a setup phase, then an access phase that completes at the
  // edge where pready is high. A span write keeps the block busy while it works out
  // the ring size, so the task returns only once busy is low again.
  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    while (busy) @(negedge clk);
  endtask

  // Lowers start and waits until every expected result has come back and the
  // block is idle. Register writes are only made after this.
  task automatic settle();
    start = 1'b0;
    while (pending_count != 0 || busy) @(negedge clk);
  endtask

  // New settings for a phase. With noisy set, the unused upper data bits carry
  // random values, which the block must ignore.
  task automatic set_limits(input logic [15:0] w, input logic [15:0] b,
                            input logic [23:0] m, input bit noisy);
    logic [15:0] hi;
    settle();
    hi = noisy ? 16'($urandom) : 16'h0;
    reg_write(REG_WINDOW, {hi, w});
    hi = noisy ? 16'($urandom) : 16'h0;
    reg_write(REG_BUCKET, {hi, b});
    hi = noisy ? 16'($urandom) : 16'h0;
    reg_write(REG_MAXC, {hi[7:0], m});
    win_us = 64'(w) * 64'(US_PER_MS);
    bkt_us = 64'(b) * 64'(US_PER_MS);
  endtask

  // Presents one transaction and returns at the falling edge after it was taken.
  // start stays high on return, so a following transaction goes out without a gap
  // unless the random idling lowers it first.
  task automatic send(input logic cmd, input logic [TIME_W-1:0] now);
    while (gaps_on && $urandom_range(99) < 17) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = {cmd, now};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Most stamps move forward by less than two buckets so that counts build up
  // and buckets roll over one at a time. The rest hit exact bucket multiples,
  // repeat the stamp, jump far inside the window (many buckets at once), jump
  // past the window, step backwards, or land anywhere in the 48-bit range.
  task automatic random_item();
    int unsigned pick;
    logic        cmd;
    pick = $urandom_range(99);
    cmd  = ($urandom_range(3) == 0) ? CMD_QUERY : CMD_CHECK;
    if (pick < 56) t_now += $urandom_range(0, 32'(bkt_us * 3 / 2));
    else if (pick < 68) t_now += 48'(bkt_us * $urandom_range(1, 4));
    else if (pick < 76) t_now = t_now;
    else if (pick < 84) t_now += $urandom_range(0, 32'(win_us));
    else if (pick < 90) t_now += 48'(win_us + $urandom_range(1, 5000));
    else if (pick < 95) t_now -= $urandom_range(1, 5000);
    else t_now = {16'($urandom), 32'($urandom)};
    send(cmd, t_now);
  endtask

  initial begin
    int n_items;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Straight out of reset both spans are zero, so limiting is disabled and
    // nothing is counted; the stamps here are the extremes of the field.
    send(CMD_CHECK, '0);
    send(CMD_QUERY, '1);

    // A four-bucket ring of one millisecond each, full at three events.
    set_limits(16'd4, 16'd1, 24'd3, 1'b0);
    send(CMD_CHECK, 48'd100000);   // far from the reset reference: clears
    send(CMD_CHECK, 48'd100999);   // one microsecond short of a whole bucket
    send(CMD_QUERY, 48'd100999);
    send(CMD_CHECK, 48'd101000);   // exactly one bucket: ring advances, reaches full
    send(CMD_CHECK, 48'd101000);
    send(CMD_CHECK, 48'd105000);   // exactly one window after the reference: no clear
    send(CMD_CHECK, 48'd109001);   // one microsecond past the window: clear
    send(CMD_QUERY, 48'd109000);   // stamp before the reference: clear
    send(CMD_CHECK, '1);
    send(CMD_CHECK, '0);

    // Widest window with the narrowest bucket caps the ring; a jump of a full
    // window passes every bucket many times over.
    set_limits(16'hFFFF, 16'd1, 24'hFFFFFF, 1'b0);
    send(CMD_CHECK, 48'd5000);
    send(CMD_CHECK, 48'd5500);
    send(CMD_CHECK, 48'd5000 + 48'd65535000);
    send(CMD_QUERY, 48'd5000 + 48'd65535000);

    // A write to the unused index must change nothing.
    settle();
    reg_write(REG_SPARE, $urandom);
    send(CMD_QUERY, 48'd5000 + 48'd65535000);

    // Window of zero disables counting; a zero limit never reports full.
    set_limits(16'd0, 16'd1, 24'd1, 1'b0);
    send(CMD_CHECK, 48'd70000);
    set_limits(16'd3, 16'd1, 24'd0, 1'b0);
    send(CMD_CHECK, 48'd80000);
    send(CMD_CHECK, 48'd80100);

    // Random phases, each with its own settings; the extremes come first.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_limits(16'd10, 16'd1, 24'd5, 1'b0);
        1: set_limits(16'hFFFF, 16'd1, 24'd0, 1'b0);
        2: set_limits(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
        3: set_limits(16'd1, 16'hFFFF, 24'd1, 1'b0);
        4: set_limits(16'd7, 16'd2, 24'd3, 1'b0);
        5: set_limits(16'd0, 16'd3, 24'd2, 1'b1);
        6: set_limits(16'd5, 16'd0, 24'd2, 1'b1);
        7: set_limits(16'($urandom_range(1, 100)), 16'($urandom_range(1, 20)),
                      24'($urandom_range(0, 40)), 1'b1);
        8: set_limits(16'($urandom_range(1, 30)), 16'($urandom_range(1, 40)),
                      24'($urandom_range(0, 40)), 1'b1);
        default: set_limits(16'($urandom_range(1, 200)), 16'($urandom_range(1, 10)),
                            24'($urandom), 1'b1);
      endcase
      if (ph == 7) begin
        settle();
        reg_write(REG_SPARE, $urandom);
      end
      // Phase four runs without any sender gaps at all.
      gaps_on = (ph != 4);
      t_now   = (ph % 2 == 1) ? {16'($urandom), 32'($urandom)} : '0;
      // With limiting disabled only a short phase is worthwhile.
      n_items = (ph == 5 || ph == 6) ? 50 : 240;
      repeat (n_items) random_item();
    end

    settle();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang: the slowest correct run is far shorter than this.
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
